@@ design/cat_pkg.sv @@
// Types and constants shared by the command line tokenizer.
// Standalone package; no dependencies.
package cat_pkg;

    localparam int START_W = 10;
    localparam int LEN_W   = 11;

    // Result queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_EQUALS = 8'h3d;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_DASH   = 3'd1,
        MODE_SHORT  = 3'd2,
        MODE_LONG   = 3'd3,
        MODE_NUMBER = 3'd4,
        MODE_STRING = 3'd5,
        MODE_QUOTED = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        KIND_EOL    = 3'd0,
        KIND_SHORT  = 3'd1,
        KIND_LONG   = 3'd2,
        KIND_EQUALS = 3'd3,
        KIND_NUMBER = 3'd4,
        KIND_STRING = 3'd5,
        KIND_BAD    = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } char_item_t;

    typedef struct packed {
        kind_t              token_kind;
        logic [START_W-1:0] token_start;
        logic [LEN_W-1:0]   token_length;
        logic               last;
    } token_t;

endpackage

@@ design/cmdline_argument_tokenizer.sv @@
// Command line tokenizer: splits a byte stream into option, number and string tokens.
// Depends on cat_pkg for the item types, character codes and lexer modes.
//
// Usage:
//   Bytes enter on the char channel (char_valid/char_stall/char_data), one transfer
//   per byte; a transfer with line_end set flushes the token in progress and adds an
//   end-of-line token. Tokens leave on the tok channel (tok_valid/tok_stall/tok_data),
//   each with kind, start, length and a last flag on the final token of a byte.
//   A byte is decoded in the cycle it is taken and its tokens go into a four-entry
//   result queue, which is registered; the tok channel reads from its head.
//   One byte is taken per cycle while char_stall is low. A byte that yields two
//   tokens adds to the queue faster than the tok channel drains it, as tokens leave
//   one at a time. The limit is the single read port of the result queue.
//   char_stall rises when fewer than two queue entries are free, so a stalled
//   receiver backs up into the byte side once three or more tokens wait; a
//   stalled token holds its value.
//   Reset (rst_n low, asynchronous) empties the queue and returns the lexer to the
//   start of a line with no token open.
module cmdline_argument_tokenizer #(
    parameter int LINE_MAX = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  cat_pkg::char_item_t char_data,
    output logic                tok_valid,
    input  logic                tok_stall,
    output cat_pkg::token_t     tok_data
);

    localparam int LW = $clog2(LINE_MAX + 1);
    localparam int SW = $clog2(LINE_MAX);
    localparam logic [LW-1:0] LMAX     = LW'(LINE_MAX);
    localparam logic [LW-1:0] LAST_POS = LW'(LINE_MAX - 1);

    function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] v);
        return (v < LMAX) ? v + LW'(1) : LMAX;
    endfunction

    function automatic cat_pkg::token_t make_tok(input cat_pkg::kind_t kind,
                                                 input logic [SW-1:0] start,
                                                 input logic [LW-1:0] len);
        cat_pkg::token_t t;
        logic [31:0]     s32;
        logic [31:0]     l32;
        s32            = 32'(start);
        l32            = 32'(len);
        t.token_kind   = kind;
        t.token_start  = s32[cat_pkg::START_W-1:0];
        t.token_length = l32[cat_pkg::LEN_W-1:0];
        t.last         = 1'b0;
        return t;
    endfunction

    // Lexer state
    cat_pkg::mode_t mode_reg, mode_next;
    logic           short_bad_reg, short_bad_next;
    logic           quote_single_reg, quote_single_next;
    logic [SW-1:0]  start_reg, start_next;
    logic [LW-1:0]  run_reg, run_next;
    logic [LW-1:0]  line_pos_reg, line_pos_next;

    // Result queue
    cat_pkg::token_t           q_reg [cat_pkg::QDEPTH];
    logic [cat_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cat_pkg::QCNT_W-1:0] count_reg, count_next;

    logic          acc;
    logic          pop;
    logic [7:0]    ch;
    logic          c_space, c_eq, c_dash, c_lower, c_digit, c_quote, c_squote;
    logic [SW-1:0] cur_start;

    logic           fin_v;
    cat_pkg::kind_t fin_kind;
    logic [LW-1:0]  fin_len;
    logic           beg;

    cat_pkg::token_t res0, res1;
    logic [1:0]      push_cnt;

    assign char_stall = (count_reg > cat_pkg::QCNT_W'(cat_pkg::QDEPTH - 2));
    assign acc        = char_valid && !char_stall;
    assign tok_valid  = (count_reg != '0);
    assign tok_data   = q_reg[rd_ptr_reg];
    assign pop        = tok_valid && !tok_stall;

    // A zero byte counts as a space
    assign ch = (char_data.char_code == 8'h00) ? cat_pkg::CH_SPACE : char_data.char_code;

    always_comb
    begin
        c_space  = (ch == cat_pkg::CH_SPACE);
        c_eq     = (ch == cat_pkg::CH_EQUALS);
        c_dash   = (ch == cat_pkg::CH_DASH);
        c_lower  = ch inside {[8'h61:8'h7a]};
        c_digit  = ch inside {[8'h30:8'h39]};
        c_quote  = ch inside {cat_pkg::CH_DQUOTE, cat_pkg::CH_SQUOTE};
        c_squote = (ch == cat_pkg::CH_SQUOTE);
    end

    assign cur_start = (line_pos_reg < LAST_POS) ? SW'(line_pos_reg) : SW'(LAST_POS);

    // Next state, plus which token (if any) closes on this transfer
    always_comb
    begin
        mode_next         = mode_reg;
        short_bad_next    = short_bad_reg;
        quote_single_next = quote_single_reg;
        start_next        = start_reg;
        run_next          = run_reg;
        line_pos_next     = line_pos_reg;
        fin_v             = 1'b0;
        fin_kind          = cat_pkg::KIND_EOL;
        fin_len           = run_reg;
        beg               = 1'b0;
        if (acc)
        begin
            if (char_data.line_end)
            begin
                fin_v = 1'b1;
                case (mode_reg)
                    cat_pkg::MODE_DASH:   fin_kind = cat_pkg::KIND_BAD;
                    cat_pkg::MODE_SHORT:  fin_kind = short_bad_reg ? cat_pkg::KIND_BAD
                                                                   : cat_pkg::KIND_SHORT;
                    cat_pkg::MODE_LONG:   fin_kind = cat_pkg::KIND_LONG;
                    cat_pkg::MODE_NUMBER: fin_kind = cat_pkg::KIND_NUMBER;
                    cat_pkg::MODE_STRING: fin_kind = cat_pkg::KIND_STRING;
                    cat_pkg::MODE_QUOTED: fin_kind = cat_pkg::KIND_BAD;
                    default:              fin_v    = 1'b0;
                endcase
                mode_next         = cat_pkg::MODE_IDLE;
                short_bad_next    = 1'b0;
                quote_single_next = 1'b0;
                start_next        = '0;
                run_next          = '0;
                line_pos_next     = '0;
            end
            else
            begin
                line_pos_next = sat_inc(line_pos_reg);
                case (mode_reg)
                    cat_pkg::MODE_DASH:
                    begin
                        run_next = sat_inc(run_reg);
                        if (c_dash)
                        begin
                            mode_next = cat_pkg::MODE_LONG;
                        end
                        else
                        begin
                            short_bad_next = !c_lower;
                            mode_next      = cat_pkg::MODE_SHORT;
                        end
                    end
                    cat_pkg::MODE_SHORT:
                    begin
                        fin_v    = 1'b1;
                        fin_kind = (short_bad_reg || !(c_space || c_eq)) ? cat_pkg::KIND_BAD
                                                                          : cat_pkg::KIND_SHORT;
                        beg      = 1'b1;
                    end
                    cat_pkg::MODE_LONG:
                    begin
                        if (c_lower)
                        begin
                            run_next = sat_inc(run_reg);
                        end
                        else
                        begin
                            fin_v    = 1'b1;
                            fin_kind = (c_space || c_eq) ? cat_pkg::KIND_LONG
                                                         : cat_pkg::KIND_BAD;
                            beg      = 1'b1;
                        end
                    end
                    cat_pkg::MODE_NUMBER:
                    begin
                        if (c_digit)
                        begin
                            run_next = sat_inc(run_reg);
                        end
                        else if (c_space)
                        begin
                            fin_v     = 1'b1;
                            fin_kind  = cat_pkg::KIND_NUMBER;
                            mode_next = cat_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            // Stray byte joins the number and spoils it
                            run_next  = sat_inc(run_reg);
                            fin_v     = 1'b1;
                            fin_kind  = cat_pkg::KIND_BAD;
                            fin_len   = sat_inc(run_reg);
                            mode_next = cat_pkg::MODE_IDLE;
                        end
                    end
                    cat_pkg::MODE_STRING:
                    begin
                        if (c_space || c_quote)
                        begin
                            fin_v    = 1'b1;
                            fin_kind = cat_pkg::KIND_STRING;
                            beg      = 1'b1;
                        end
                        else
                        begin
                            run_next = sat_inc(run_reg);
                        end
                    end
                    cat_pkg::MODE_QUOTED:
                    begin
                        if (c_quote)
                        begin
                            fin_v = 1'b1;
                            if (c_squote == quote_single_reg)
                            begin
                                run_next  = sat_inc(run_reg);
                                fin_kind  = cat_pkg::KIND_STRING;
                                fin_len   = sat_inc(run_reg);
                                mode_next = cat_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                fin_kind = cat_pkg::KIND_BAD;
                                beg      = 1'b1;
                            end
                        end
                        else
                        begin
                            run_next = sat_inc(run_reg);
                        end
                    end
                    default:
                    begin
                        beg = 1'b1;
                    end
                endcase
                // Open a new token with this byte
                if (beg)
                begin
                    mode_next = cat_pkg::MODE_IDLE;
                    if (!c_space)
                    begin
                        start_next = cur_start;
                        run_next   = LW'(1);
                        if (c_dash)
                        begin
                            mode_next = cat_pkg::MODE_DASH;
                        end
                        else if (c_digit)
                        begin
                            mode_next = cat_pkg::MODE_NUMBER;
                        end
                        else if (c_quote)
                        begin
                            quote_single_next = c_squote;
                            mode_next         = cat_pkg::MODE_QUOTED;
                        end
                        else if (!c_eq)
                        begin
                            mode_next = cat_pkg::MODE_STRING;
                        end
                    end
                end
            end
        end
    end

    // Assemble up to two tokens for this transfer, in order
    always_comb
    begin
        cat_pkg::token_t second;
        logic            has_second;
        logic            eol;
        logic            beg_eq;
        eol    = acc && char_data.line_end;
        beg_eq = beg && c_eq;
        if (eol)
        begin
            second = make_tok(cat_pkg::KIND_EOL, cur_start, '0);
        end
        else
        begin
            second = make_tok(cat_pkg::KIND_EQUALS, cur_start, LW'(1));
        end
        has_second = eol || beg_eq;
        res0       = make_tok(fin_kind, start_reg, fin_len);
        res1       = second;
        res1.last  = 1'b1;
        if (fin_v)
        begin
            res0.last = !has_second;
            push_cnt  = has_second ? 2'd2 : 2'd1;
        end
        else
        begin
            res0      = second;
            res0.last = 1'b1;
            push_cnt  = has_second ? 2'd1 : 2'd0;
        end
    end

    assign count_next = count_reg + cat_pkg::QCNT_W'(push_cnt) - cat_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= cat_pkg::MODE_IDLE;
            short_bad_reg    <= 1'b0;
            quote_single_reg <= 1'b0;
            start_reg        <= '0;
            run_reg          <= '0;
            line_pos_reg     <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            short_bad_reg    <= short_bad_next;
            quote_single_reg <= quote_single_next;
            start_reg        <= start_next;
            run_reg          <= run_next;
            line_pos_reg     <= line_pos_next;
            wr_ptr_reg       <= wr_ptr_reg + cat_pkg::QPTR_W'(push_cnt);
            rd_ptr_reg       <= rd_ptr_reg + cat_pkg::QPTR_W'(pop);
            count_reg        <= count_next;
        end
    end

    // Queue payload: no reset
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            q_reg[wr_ptr_reg + cat_pkg::QPTR_W'(1)] <= res1;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cat_pkg::QCNT_W'(cat_pkg::QDEPTH))
        else $error("result queue overflow");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        acc && char_data.line_end |=> line_pos_reg == '0 && mode_reg == cat_pkg::MODE_IDLE)
        else $error("line end did not restart the line");

    a_eol_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        acc && char_data.line_end |=> count_reg != '0)
        else $error("line end left no token queued");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= LMAX && line_pos_reg <= LMAX)
        else $error("length or position past line size");

endmodule

@@ tb/sv/cmdline_argument_tokenizer_tb.sv @@
// Self-checking testbench for cmdline_argument_tokenizer: directed lines, then random lines.
// Holds its own token predictor and scoreboard; depends on cat_pkg and the tokenizer RTL.

class token_scoreboard;
    localparam int LINE_LIMIT = 1024;

    cat_pkg::mode_t lex_state;
    bit             short_bad;
    bit             quote_single;
    int             tok_start;
    int             run_len;
    int             line_pos;

    cat_pkg::token_t step_tokens[$];
    cat_pkg::token_t expected_q[$];
    int              errors;
    int              checked;
    int              chars_seen;
    int              lines_seen;

    function new();
        clear_line();
    endfunction

    function void clear_line();
        lex_state    = cat_pkg::MODE_IDLE;
        short_bad    = 1'b0;
        quote_single = 1'b0;
        tok_start    = 0;
        run_len      = 0;
        line_pos     = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function bit is_quote(logic [7:0] c);
        return c == cat_pkg::CH_DQUOTE || c == cat_pkg::CH_SQUOTE;
    endfunction

    function int clamp_start(int p);
        return p < LINE_LIMIT - 1 ? p : LINE_LIMIT - 1;
    endfunction

    function int bump(int v);
        return v < LINE_LIMIT ? v + 1 : LINE_LIMIT;
    endfunction

    function void emit(cat_pkg::kind_t kind, int s, int len);
        cat_pkg::token_t t;
        if (step_tokens.size() >= 2)
            return;
        t.token_kind   = kind;
        t.token_start  = s[cat_pkg::START_W-1:0];
        t.token_length = len[cat_pkg::LEN_W-1:0];
        t.last         = 1'b0;
        step_tokens    = {step_tokens, t};
    endfunction

    function void close_token(cat_pkg::kind_t kind);
        emit(kind, tok_start, run_len);
        lex_state = cat_pkg::MODE_IDLE;
    endfunction

    function void open_token(logic [7:0] c, int p);
        lex_state = cat_pkg::MODE_IDLE;
        if (c == cat_pkg::CH_SPACE)
            return;
        tok_start = clamp_start(p);
        run_len   = 1;
        if (c == cat_pkg::CH_DASH)
            lex_state = cat_pkg::MODE_DASH;
        else if (c == cat_pkg::CH_EQUALS)
            emit(cat_pkg::KIND_EQUALS, tok_start, 1);
        else if (is_digit(c))
            lex_state = cat_pkg::MODE_NUMBER;
        else if (is_quote(c))
        begin
            quote_single = (c == cat_pkg::CH_SQUOTE);
            lex_state    = cat_pkg::MODE_QUOTED;
        end
        else
            lex_state = cat_pkg::MODE_STRING;
    endfunction

    function void take_char(logic [7:0] c, int p);
        bit sep;
        sep = (c == cat_pkg::CH_SPACE) || (c == cat_pkg::CH_EQUALS);
        case (lex_state)
            cat_pkg::MODE_DASH:
            begin
                run_len = bump(run_len);
                if (c == cat_pkg::CH_DASH)
                    lex_state = cat_pkg::MODE_LONG;
                else
                begin
                    short_bad = !is_lower(c);
                    lex_state = cat_pkg::MODE_SHORT;
                end
            end
            cat_pkg::MODE_SHORT:
            begin
                close_token((short_bad || !sep) ? cat_pkg::KIND_BAD : cat_pkg::KIND_SHORT);
                open_token(c, p);
            end
            cat_pkg::MODE_LONG:
            begin
                if (is_lower(c))
                    run_len = bump(run_len);
                else
                begin
                    close_token(sep ? cat_pkg::KIND_LONG : cat_pkg::KIND_BAD);
                    open_token(c, p);
                end
            end
            cat_pkg::MODE_NUMBER:
            begin
                if (is_digit(c))
                    run_len = bump(run_len);
                else if (c == cat_pkg::CH_SPACE)
                    close_token(cat_pkg::KIND_NUMBER);
                else
                begin
                    // the offending char belongs to the bad token
                    run_len = bump(run_len);
                    close_token(cat_pkg::KIND_BAD);
                end
            end
            cat_pkg::MODE_STRING:
            begin
                if (c == cat_pkg::CH_SPACE || is_quote(c))
                begin
                    close_token(cat_pkg::KIND_STRING);
                    open_token(c, p);
                end
                else
                    run_len = bump(run_len);
            end
            cat_pkg::MODE_QUOTED:
            begin
                if (!is_quote(c))
                    run_len = bump(run_len);
                else if ((c == cat_pkg::CH_SQUOTE) == quote_single)
                begin
                    run_len = bump(run_len);
                    close_token(cat_pkg::KIND_STRING);
                end
                else
                begin
                    close_token(cat_pkg::KIND_BAD);
                    open_token(c, p);
                end
            end
            default:
                open_token(c, p);
        endcase
    endfunction

    function void flush_line();
        case (lex_state)
            cat_pkg::MODE_DASH:   close_token(cat_pkg::KIND_BAD);
            cat_pkg::MODE_SHORT:  close_token(short_bad ? cat_pkg::KIND_BAD
                                                        : cat_pkg::KIND_SHORT);
            cat_pkg::MODE_LONG:   close_token(cat_pkg::KIND_LONG);
            cat_pkg::MODE_NUMBER: close_token(cat_pkg::KIND_NUMBER);
            cat_pkg::MODE_STRING: close_token(cat_pkg::KIND_STRING);
            cat_pkg::MODE_QUOTED: close_token(cat_pkg::KIND_BAD);
            default:              ;
        endcase
        emit(cat_pkg::KIND_EOL, clamp_start(line_pos), 0);
    endfunction

    // Predict the tokens that one accepted char transfer produces.
    function void note_char(cat_pkg::char_item_t item);
        logic [7:0] c;
        step_tokens.delete();
        if (item.line_end)
        begin
            flush_line();
            clear_line();
            lines_seen++;
        end
        else
        begin
            c = item.char_code;
            if (c == 8'h00)
                c = cat_pkg::CH_SPACE;
            take_char(c, line_pos);
            line_pos = bump(line_pos);
            chars_seen++;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        expected_q = {expected_q, step_tokens};
    endfunction

    task check_token(cat_pkg::token_t got);
        cat_pkg::token_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected token kind %0d start %0d length %0d",
                             got.token_kind, got.token_start, got.token_length));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.token_kind !== want.token_kind)
            report($sformatf("token %0d kind %0d, want %0d",
                             checked, got.token_kind, want.token_kind));
        if (got.token_start !== want.token_start)
            report($sformatf("token %0d start %0d, want %0d",
                             checked, got.token_start, want.token_start));
        if (got.token_length !== want.token_length)
            report($sformatf("token %0d length %0d, want %0d",
                             checked, got.token_length, want.token_length));
        if (got.last !== want.last)
            report($sformatf("token %0d last %0b, want %0b", checked, got.last, want.last));
    endtask
endclass

module cmdline_argument_tokenizer_tb;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 20;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                char_valid = 1'b0;
    logic                char_stall;
    cat_pkg::char_item_t char_data = '0;
    logic                tok_valid;
    logic                tok_stall = 1'b0;
    cat_pkg::token_t     tok_data;

    token_scoreboard sb = new();

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;
    int         items_sent = 0;
    int         quiet_cycles = 0;
    bit         moved;
    logic [7:0] line_q[$];

    cmdline_argument_tokenizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_data   (tok_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Monitor both channels and watch for a stuck handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (char_valid && !char_stall)
            begin
                sb.note_char(char_data);
                moved = 1'b1;
            end
            if (tok_valid && !tok_stall)
            begin
                sb.check_token(tok_data);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                sb.report("no transfer for too long, giving up");
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Token receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                tok_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            tok_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_char(input logic [7:0] code, input logic eol);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{char_code: code, line_end: eol};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // The char code rides along on a line end but must be ignored.
    task automatic send_eol();
        send_char(8'($urandom_range(1, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_char(line_q[i], 1'b0);
        send_eol();
    endtask

    // Hold the sender until every expected token has been checked.
    task automatic wait_drained();
        char_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic void add_byte(logic [7:0] c);
        line_q = {line_q, c};
    endfunction

    function automatic logic [7:0] rand_lower();
        return 8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range("0", "9"));
    endfunction

    function automatic void push_run(int n, bit digits);
        for (int i = 0; i < n; i++)
            add_byte(digits ? rand_digit() : rand_lower());
    endfunction

    // Build a mostly well-formed line with random content and some noise.
    function automatic void make_line(int words);
        logic [7:0] q;
        line_q.delete();
        for (int w = 0; w < words; w++)
        begin
            if (w > 0 || $urandom_range(3) == 0)
                repeat ($urandom_range(1, 2)) add_byte(cat_pkg::CH_SPACE);
            case ($urandom_range(9))
                0:
                begin
                    add_byte(cat_pkg::CH_DASH);
                    add_byte($urandom_range(9) == 0 ? 8'($urandom_range(1, 255))
                                                    : rand_lower());
                end
                1:
                begin
                    add_byte(cat_pkg::CH_DASH);
                    add_byte(cat_pkg::CH_DASH);
                    push_run($urandom_range(1, 6), 1'b0);
                end
                2:
                begin
                    add_byte(cat_pkg::CH_DASH);
                    add_byte(cat_pkg::CH_DASH);
                    push_run($urandom_range(0, 5), 1'b0);
                    add_byte(cat_pkg::CH_EQUALS);
                    push_run($urandom_range(1, 4), 1'b1);
                end
                3:
                    push_run($urandom_range(1, 5), 1'b1);
                4:
                begin
                    add_byte($urandom_range(1) ? rand_lower() : 8'($urandom_range("A", "Z")));
                    for (int i = $urandom_range(0, 5); i > 0; i--)
                        add_byte($urandom_range(3) == 0 ? rand_digit() : rand_lower());
                end
                5:
                begin
                    q = $urandom_range(1) ? cat_pkg::CH_SQUOTE : cat_pkg::CH_DQUOTE;
                    add_byte(q);
                    for (int i = $urandom_range(0, 5); i > 0; i--)
                        add_byte($urandom_range(4) == 0 ? cat_pkg::CH_SPACE : rand_lower());
                    if ($urandom_range(7) == 0)
                        q = (q == cat_pkg::CH_SQUOTE) ? cat_pkg::CH_DQUOTE : cat_pkg::CH_SQUOTE;
                    if ($urandom_range(9) != 0)
                        add_byte(q);
                end
                6:
                    add_byte(cat_pkg::CH_EQUALS);
                7:
                begin
                    add_byte(cat_pkg::CH_DASH);
                    add_byte(rand_lower());
                    add_byte(cat_pkg::CH_EQUALS);
                    push_run($urandom_range(1, 3), 1'b1);
                end
                8:
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(1, 255)));
                default:
                begin
                    // tokens glued to something that breaks them
                    add_byte($urandom_range(1) ? cat_pkg::CH_DASH : rand_digit());
                    push_run($urandom_range(1, 3), 1'b0);
                    add_byte(rand_digit());
                end
            endcase
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_byte(cat_pkg::CH_SPACE);
    endfunction

    task automatic run_random(input int target);
        while (items_sent < target)
        begin
            make_line($urandom_range(0, 6));
            send_line();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short options good and bad, long option, equals, broken number.
        send_text("-a -B --op=4x");
        send_eol();
        // Mismatched quotes chain into new quoted tokens; line ends inside a quote.
        send_text("'q\"r' -");
        send_eol();
        // Byte extremes as a string, then a lone dash at line end.
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b0);
        send_text(" -");
        send_eol();
        send_text("-z");
        send_eol();

        send_idle_pct = 28;
        recv_idle_pct = 85;
        run_random(150);
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 28;
        run_random(280);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_random(400);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d tokens never arrived", sb.expected_q.size()));

        $display("Run covered %0d chars in %0d lines and checked %0d tokens,",
                 sb.chars_seen, sb.lines_seen, sb.checked);
        $display("with both sides stalling, a long receiver hold-off and a full drain.");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
